[rtl/salt_pkg.sv]
package salt_pkg;
  localparam int NumSets   = 16;
  localparam int NumWays   = 4;
  localparam int LineBytes = 64;
  localparam int SetW      = (NumSets > 1) ? $clog2(NumSets) : 1;
  localparam int OffW      = $clog2(LineBytes);
  localparam int LineW     = 32 - OffW;
  localparam int WayW      = 2;
  localparam int StampW    = 48;
  localparam int QDepth    = 2;

  typedef enum logic [2:0] {
    FUNC_LOOKUP = 3'd0,
    FUNC_FILL   = 3'd1,
    FUNC_INVAL  = 3'd2,
    FUNC_EVICT  = 3'd3,
    FUNC_DIRTY  = 3'd4
  } func_e;

  typedef struct packed {
    logic [2:0]        func;
    logic [LineW-1:0]  line;
    logic [StampW-1:0] now;
    logic              fill_dirty;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [WayW-1:0]   way;
    logic [StampW-1:0] ready_stamp;
    logic              victim_valid;
    logic              victim_dirty;
    logic [25:0]       victim_line;
    logic [StampW-1:0] victim_stamp;
  } rsp_t;
endpackage

[rtl/set_assoc_cache_lru_tags.sv]
// Tag, valid, dirty and stamp store of a 16-set, 4-way cache with LRU
// replacement.
// Command channel: present func_i, addr_i, now_i, fill_dirty_i with start_i;
// the transfer takes place at the edge where start_i is high and busy low.
// Commands enter a two-entry queue; the back end takes one per cycle.
// Result channel: done_o is high for one cycle with the result fields;
// exactly one result per command, in order.
// Each command passes the queue, then the tag update stage, to done_o.
// Throughput: one command per cycle, bounded by the single
// read-modify-write of the set state in the back end.
// busy rises only when the queue is full, which does not happen while
// the back end drains every cycle.
// Reset empties the queue and clears every tag, stamp, valid and dirty bit.
// The receiver cannot stall: done_o is not held off.
module set_assoc_cache_lru_tags import salt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [2:0]        func_i,
  input  logic [31:0]       addr_i,
  input  logic [StampW-1:0] now_i,
  input  logic              fill_dirty_i,
  output logic              busy,
  output logic              done_o,
  output logic              hit_o,
  output logic [1:0]        way_o,
  output logic [StampW-1:0] ready_stamp_o,
  output logic              victim_valid_o,
  output logic              victim_dirty_o,
  output logic [25:0]       victim_line_o,
  output logic [StampW-1:0] victim_stamp_o
);
  logic q_valid, pop;
  req_t head;
  rsp_t rsp;

  salt_front u_front (
    .clk_i, .rst_ni, .start_i, .func_i, .addr_i, .now_i, .fill_dirty_i,
    .pop_i(pop), .busy_o(busy), .q_valid_o(q_valid), .q_head_o(head)
  );

  salt_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_head_i(head),
    .pop_o(pop), .valid_o(done_o), .rsp_o(rsp)
  );

  assign hit_o          = rsp.hit;
  assign way_o          = rsp.way;
  assign ready_stamp_o  = rsp.ready_stamp;
  assign victim_valid_o = rsp.victim_valid;
  assign victim_dirty_o = rsp.victim_dirty;
  assign victim_line_o  = rsp.victim_line;
  assign victim_stamp_o = rsp.victim_stamp;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid |=> done_o) else $error("result lost");
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("queue filled");
  a_vic_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !victim_valid_o |-> !victim_dirty_o && victim_stamp_o == '0)
    else $error("stale victim");
endmodule

[rtl/salt_front.sv]
module salt_front import salt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [2:0]        func_i,
  input  logic [31:0]       addr_i,
  input  logic [StampW-1:0] now_i,
  input  logic              fill_dirty_i,
  input  logic              pop_i,
  output logic              busy_o,
  output logic              q_valid_o,
  output req_t              q_head_o
);
  req_t                q_mem [QDepth];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          cnt_q;
  logic                push;

  assign busy_o    = (cnt_q == 2'(QDepth));
  assign push      = start_i && !busy_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_head_o  = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= '{func: func_i, line: addr_i[31:OffW], now: now_i,
                           fill_dirty: fill_dirty_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end
endmodule

[rtl/salt_back.sv]
module salt_back import salt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  req_t q_head_i,
  output logic pop_o,
  output logic valid_o,
  output rsp_t rsp_o
);
  logic [NumWays-1:0][LineW-1:0]  tag_q   [NumSets];
  logic [NumWays-1:0][StampW-1:0] touch_q [NumSets];
  logic [NumWays-1:0][StampW-1:0] rdy_q   [NumSets];
  logic [NumSets-1:0][NumWays-1:0] vld_q, drt_q;

  logic [SetW-1:0] set;
  logic [NumWays-1:0] match;
  logic hit, any_inv, do_repl, do_kill;
  logic [WayW-1:0] mway, vway, inv_w, lru_w, sel;
  logic [StampW-1:0] oldest;

  assign pop_o = q_valid_i;
  assign set   = (NumSets > 1) ? SetW'(q_head_i.line) : '0;

  always_comb begin
    hit = 1'b0; mway = '0; any_inv = 1'b0; inv_w = '0;
    lru_w = '0; oldest = '1;
    for (int w = NumWays - 1; w >= 0; w--) begin
      match[w] = vld_q[set][w] && tag_q[set][w] == q_head_i.line;
      if (match[w]) begin hit = 1'b1; mway = WayW'(w); end
      if (!vld_q[set][w]) begin any_inv = 1'b1; inv_w = WayW'(w); end
    end
    for (int w = 0; w < NumWays; w++) begin
      if (touch_q[set][w] <= oldest) begin
        oldest = touch_q[set][w]; lru_w = WayW'(w);
      end
    end
    vway    = any_inv ? inv_w : lru_w;
    do_repl = (q_head_i.func == FUNC_FILL) && !hit;
    do_kill = (q_head_i.func == FUNC_EVICT) || (q_head_i.func == FUNC_INVAL && hit);
    sel     = (do_repl || q_head_i.func == FUNC_EVICT) ? vway : mway;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_o <= '0;
      for (int s = 0; s < NumSets; s++) begin
        tag_q[s] <= '0; touch_q[s] <= '0; rdy_q[s] <= '0;
      end
    end else if (q_valid_i) begin
      rsp_o.hit          <= hit;
      rsp_o.way          <= sel;
      rsp_o.ready_stamp  <= hit ? rdy_q[set][mway] : '0;
      rsp_o.victim_valid <= (do_repl || do_kill) && vld_q[set][sel];
      rsp_o.victim_dirty <= (do_repl || do_kill) && vld_q[set][sel] && drt_q[set][sel];
      rsp_o.victim_line  <= ((do_repl || do_kill) && vld_q[set][sel])
                            ? 26'(tag_q[set][sel]) : '0;
      rsp_o.victim_stamp <= ((do_repl || do_kill) && vld_q[set][sel])
                            ? touch_q[set][sel] : '0;
      if (do_repl) begin
        tag_q[set][sel] <= q_head_i.line;
        rdy_q[set][sel] <= q_head_i.now;
      end
      if (do_repl || (q_head_i.func == FUNC_LOOKUP && hit))
        touch_q[set][sel] <= q_head_i.now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0; drt_q <= '0; valid_o <= 1'b0;
    end else begin
      valid_o <= q_valid_i;
      if (q_valid_i) begin
        if (do_repl) begin
          vld_q[set][sel] <= 1'b1; drt_q[set][sel] <= q_head_i.fill_dirty;
        end else if (do_kill) begin
          vld_q[set][sel] <= 1'b0; drt_q[set][sel] <= 1'b0;
        end else if (q_head_i.func == FUNC_DIRTY && hit) begin
          drt_q[set][sel] <= 1'b1;
        end
      end
    end
  end
endmodule

[tb/set_assoc_cache_lru_tags_tb.sv]
`timescale 1ns / 100ps

class cache_tag_scoreboard;
  logic [25:0] tag_q [64];
  bit          valid_q [64];
  bit          dirty_q [64];
  logic [47:0] touch_q [64];
  logic [47:0] ready_q [64];
  salt_pkg::rsp_t pending_q[$];
  int          errors;

  function void clear();
    for (int i = 0; i < 64; i++) begin
      tag_q[i] = '0;
      valid_q[i] = 0;
      dirty_q[i] = 0;
      touch_q[i] = '0;
      ready_q[i] = '0;
    end
    pending_q.delete();
    errors = 0;
  endfunction

  function int lru_way(int base);
    int best;
    logic [47:0] oldest;
    best = 0;
    oldest = '1;
    for (int w = 0; w < 4; w++) if (!valid_q[base+w]) return w;
    for (int w = 0; w < 4; w++) begin
      if (touch_q[base+w] <= oldest) begin
        oldest = touch_q[base+w];
        best = w;
      end
    end
    return best;
  endfunction

  function void report_victim(int e, ref salt_pkg::rsp_t r);
    if (valid_q[e]) begin
      r.victim_valid = 1;
      r.victim_dirty = dirty_q[e];
      r.victim_line = tag_q[e];
      r.victim_stamp = touch_q[e];
    end
  endfunction

  function void note_transfer(logic [2:0] func, logic [31:0] addr, logic [47:0] now,
                              logic fdirty);
    salt_pkg::rsp_t r;
    logic [25:0] line;
    int base, e, match, w;
    bit hit;
    line = addr[31:6];
    base = line[3:0] * 4;
    match = 0;
    hit = 0;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      if (!hit && valid_q[base+i] && tag_q[base+i] == line) begin
        hit = 1;
        match = i;
      end
    end
    if (hit) begin
      r.hit = 1;
      r.way = match[1:0];
      r.ready_stamp = ready_q[base+match];
    end
    e = base + match;
    case (func)
      salt_pkg::FUNC_LOOKUP: if (hit) touch_q[e] = now;
      salt_pkg::FUNC_FILL: if (!hit) begin
        w = lru_way(base);
        e = base + w;
        r.way = w[1:0];
        report_victim(e, r);
        tag_q[e] = line;
        valid_q[e] = 1;
        dirty_q[e] = fdirty;
        touch_q[e] = now;
        ready_q[e] = now;
      end
      salt_pkg::FUNC_INVAL: if (hit) begin
        report_victim(e, r);
        valid_q[e] = 0;
        dirty_q[e] = 0;
      end
      salt_pkg::FUNC_EVICT: begin
        w = lru_way(base);
        e = base + w;
        r.way = w[1:0];
        report_victim(e, r);
        valid_q[e] = 0;
        dirty_q[e] = 0;
      end
      salt_pkg::FUNC_DIRTY: if (hit) dirty_q[e] = 1;
      default: ;
    endcase
    pending_q.push_back(r);
  endfunction

  function void check_result(salt_pkg::rsp_t got);
    salt_pkg::rsp_t exp;
    if (pending_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    exp = pending_q.pop_front();
    if (got !== exp) begin
      errors++;
      if (errors <= 10) $display("mismatch: expected %h actual %h", exp, got);
    end
  endfunction
endclass

module set_assoc_cache_lru_tags_tb;
  import salt_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic [2:0]  func_i = '0;
  logic [31:0] addr_i = '0;
  logic [47:0] now_i = '0;
  logic        fill_dirty_i = 0;
  logic        busy, done_o, hit_o, victim_valid_o, victim_dirty_o;
  logic [1:0]  way_o;
  logic [47:0] ready_stamp_o, victim_stamp_o;
  logic [25:0] victim_line_o;

  cache_tag_scoreboard sb = new();
  int          idle_pct = 0;
  longint      cycles = 0;
  logic [47:0] stamp_now = 0;
  logic [31:0] hot_addr [8];

  set_assoc_cache_lru_tags uut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    rsp_t got;
    if (rst_ni && done_o) begin
      got.hit = hit_o;
      got.way = way_o;
      got.ready_stamp = ready_stamp_o;
      got.victim_valid = victim_valid_o;
      got.victim_dirty = victim_dirty_o;
      got.victim_line = victim_line_o;
      got.victim_stamp = victim_stamp_o;
      sb.check_result(got);
    end
  end

  task automatic send(logic [2:0] f, logic [31:0] a, logic [47:0] n, logic d);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 0;
      @(posedge clk_i);
    end
    start_i <= 1;
    func_i <= f;
    addr_i <= a;
    now_i <= n;
    fill_dirty_i <= d;
    do @(posedge clk_i); while (busy);
    sb.note_transfer(f, a, n, d);
  endtask

  task automatic send_random();
    logic [31:0] a;
    logic [2:0] f;
    logic [47:0] n;
    int pick;
    pick = $urandom_range(99);
    a = (pick < 80) ? hot_addr[3'($urandom_range(7))] + ($urandom_range(3) << 10)
                    : $urandom;
    pick = $urandom_range(99);
    if (pick < 30) f = FUNC_LOOKUP;
    else if (pick < 60) f = FUNC_FILL;
    else if (pick < 70) f = FUNC_INVAL;
    else if (pick < 80) f = FUNC_EVICT;
    else if (pick < 92) f = FUNC_DIRTY;
    else f = 3'($urandom_range(7));
    stamp_now = stamp_now + $urandom_range(5);
    n = ($urandom_range(19) == 0) ? 48'({$urandom, $urandom}) : stamp_now;
    if ($urandom_range(9) == 0) n = 48'($urandom_range(3));
    send(f, a, n, 1'($urandom_range(1)));
  endtask

  task automatic drain();
    start_i <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int pcts [4] = '{0, 58, 0, 12};
    sb.clear();
    for (int i = 0; i < 8; i++) hot_addr[i] = $urandom & 32'hFFFF_F3FF;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send(FUNC_LOOKUP, 32'h0, 48'h0, 0);
    send(FUNC_FILL, 32'h0, 48'h0, 1);
    send(FUNC_FILL, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0);
    send(FUNC_LOOKUP, 32'hFFFF_FFC0, 48'h5, 0);
    for (int w = 0; w < 5; w++) send(FUNC_FILL, 32'h40 + w * 32'h400, 48'h7, w[0]);
    send(FUNC_LOOKUP, 32'h440, 48'h9, 0);
    send(FUNC_FILL, 32'h1440, 48'h9, 1);
    send(FUNC_DIRTY, 32'h840, 48'h0, 0);
    send(FUNC_DIRTY, 32'h12340, 48'h0, 0);
    send(FUNC_INVAL, 32'h840, 48'h0, 0);
    send(FUNC_INVAL, 32'h840, 48'h0, 0);
    for (int i = 0; i < 5; i++) send(FUNC_EVICT, 32'h40, 48'h0, 0);
    send(3'd5, 32'hFFFF_FFFF, 48'h1, 1);
    send(3'd6, 32'h0, 48'h1, 0);
    send(3'd7, 32'h0, 48'h1, 1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = pcts[ph];
      for (int i = 0; i < 320; i++) send_random();
      if (ph == 1) drain();
    end
    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/salt_pkg.sv
rtl/salt_front.sv
rtl/salt_back.sv
rtl/set_assoc_cache_lru_tags.sv
tb/set_assoc_cache_lru_tags_tb.sv
